// ===== design/pde_pkg.sv =====
// Shared types, constants and helper functions for the percent escape decoder.
// Used by the front end, the job queue, the back end and the top level.
package pde_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned HoldDepth   = 5;
   localparam int unsigned JobBytes    = HoldDepth + 1;
   localparam int unsigned CountWidth  = $clog2(JobBytes + 1);
   localparam int unsigned QueueDepth  = 2;

   localparam logic [ByteWidth-1:0] CharPercent = 8'h25;
   localparam logic [ByteWidth-1:0] CharLowerU  = 8'h75;
   localparam logic [ByteWidth-1:0] CharUpperU  = 8'h55;
   localparam logic [ByteWidth-1:0] CharZero    = 8'h30;
   localparam logic [ByteWidth-1:0] CharNine    = 8'h39;
   localparam logic [ByteWidth-1:0] CharLowerA  = 8'h61;
   localparam logic [ByteWidth-1:0] CharLowerF  = 8'h66;
   localparam logic [ByteWidth-1:0] CharUpperA  = 8'h41;
   localparam logic [ByteWidth-1:0] CharUpperF  = 8'h46;
   localparam logic [3:0]           HexTen      = 4'd10;

   // One decoded batch: every byte that a single request gives rise to.
   typedef struct packed {
      logic [JobBytes-1:0][ByteWidth-1:0] bytes;
      logic [CountWidth-1:0]              count;
      logic                               fin;
   } job_type;

   function automatic logic is_hex(input logic [ByteWidth-1:0] b);
      return ((b >= CharZero) && (b <= CharNine)) ||
             ((b >= CharLowerA) && (b <= CharLowerF)) ||
             ((b >= CharUpperA) && (b <= CharUpperF));
   endfunction

   function automatic logic is_u(input logic [ByteWidth-1:0] b);
      return (b == CharLowerU) || (b == CharUpperU);
   endfunction

   // Value of a hex digit, zero for anything that is not one.
   function automatic logic [3:0] hex_nibble(input logic [ByteWidth-1:0] b);
      logic [ByteWidth-1:0] diff;
      diff = '0;
      if ((b >= CharZero) && (b <= CharNine)) begin
         diff = b - CharZero;
         return diff[3:0];
      end else if ((b >= CharLowerA) && (b <= CharLowerF)) begin
         diff = b - CharLowerA;
         return diff[3:0] + HexTen;
      end else if ((b >= CharUpperA) && (b <= CharUpperF)) begin
         diff = b - CharUpperA;
         return diff[3:0] + HexTen;
      end
      return 4'd0;
   endfunction

   function automatic logic [ByteWidth-1:0] pair_value(input logic [ByteWidth-1:0] hi,
                                                       input logic [ByteWidth-1:0] lo);
      return {hex_nibble(hi), hex_nibble(lo)};
   endfunction

endpackage

// ===== design/pde_front.sv =====
// Front end of the percent escape decoder: holds the pending escape bytes and
// turns each request into a batch of decoded bytes. Depends on pde_pkg.
module pde_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [pde_pkg::ByteWidth-1:0] in_byte,
   input  logic                          final_byte,
   output logic                          push,
   output pde_pkg::job_type              job
);
   import pde_pkg::*;

   logic [ByteWidth-1:0]  held_ff [HoldDepth];
   logic [ByteWidth-1:0]  held_in [HoldDepth];
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;

   always_comb begin
      logic [ByteWidth-1:0]  obytes [JobBytes];
      logic [CountWidth-1:0] n;
      logic [CountWidth-1:0] c;
      logic                  done;
      logic                  hex;
      logic                  uform;
      logic [ByteWidth-1:0]  first_pair;

      for (int i = 0; i < JobBytes; i++) obytes[i] = '0;
      for (int i = 0; i < HoldDepth; i++) held_in[i] = held_ff[i];
      n          = '0;
      c          = count_ff;
      done       = 1'b0;
      hex        = is_hex(in_byte);
      uform      = (count_ff >= CountWidth'(2)) && is_u(held_ff[1]);
      first_pair = pair_value(held_ff[2], held_ff[3]);

      if (c != '0) begin
         if (c == CountWidth'(1)) begin
            if (hex || is_u(in_byte)) begin
               held_in[1] = in_byte;
               c          = CountWidth'(2);
               done       = 1'b1;
            end
         end else if ((c == CountWidth'(2)) && !uform) begin
            if (hex) begin
               obytes[0] = pair_value(held_ff[1], in_byte);
               n         = CountWidth'(1);
               c         = '0;
               done      = 1'b1;
            end
         end else if (c < CountWidth'(HoldDepth)) begin
            if (hex) begin
               held_in[c[2:0]] = in_byte;
               c               = c + CountWidth'(1);
               done            = 1'b1;
            end
         end else begin
            if (hex) begin
               obytes[0] = first_pair;
               obytes[1] = pair_value(held_ff[4], in_byte);
               n         = CountWidth'(2);
               c         = '0;
               done      = 1'b1;
            end
         end
         // Broken escape: the held bytes go out as they came in.
         if (!done) begin
            for (int i = 0; i < HoldDepth; i++) begin
               if (CountWidth'(i) < c) obytes[i] = held_ff[i];
            end
            n = c;
            c = '0;
         end
      end

      if (!done) begin
         if (in_byte == CharPercent) begin
            held_in[0] = in_byte;
            c          = CountWidth'(1);
         end else begin
            obytes[n[2:0]] = in_byte;
            n              = n + CountWidth'(1);
         end
      end

      // End of text inside an escape: flush what is held.
      if (final_byte) begin
         for (int i = 0; i < HoldDepth; i++) begin
            if (CountWidth'(i) < c) obytes[n[2:0] + 3'(i)] = held_in[i];
         end
         n = n + c;
         c = '0;
      end

      count_in = c;
      for (int i = 0; i < JobBytes; i++) job.bytes[i] = obytes[i];
      job.count = n;
      job.fin   = final_byte;
      push      = accept && (n != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < HoldDepth; i++) held_ff[i] <= '0;
      end else if (accept) begin
         count_ff <= count_in;
         for (int i = 0; i < HoldDepth; i++) held_ff[i] <= held_in[i];
      end
   end

endmodule

// ===== design/pde_queue.sv =====
// Short batch queue between the front end and the back end of the percent
// escape decoder. Depends on pde_pkg for the batch type and depth.
module pde_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pde_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output pde_pkg::job_type head
);
   import pde_pkg::*;

   localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned LvlWidth = $clog2(QueueDepth + 1);

   job_type               slots [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [LvlWidth-1:0]   level_ff;
   logic [LvlWidth-1:0]   level_in;

   assign full  = (level_ff == LvlWidth'(QueueDepth));
   assign empty = (level_ff == '0);
   assign head  = slots[rd_ptr_ff];

   always_comb begin
      level_in = level_ff;
      if (push && !pop) level_in = level_ff + LvlWidth'(1);
      else if (pop && !push) level_in = level_ff - LvlWidth'(1);
   end

   always_ff @(posedge clock) begin
      if (push) slots[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0
                                                                 : wr_ptr_ff + PtrWidth'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0
                                                                 : rd_ptr_ff + PtrWidth'(1);
         end
      end
   end

endmodule

// ===== design/pde_back.sv =====
// Back end of the percent escape decoder: walks the batch at the head of the
// queue and drives the registered result channel. Depends on pde_pkg.
module pde_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          empty,
   input  pde_pkg::job_type              head,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [pde_pkg::ByteWidth-1:0] out_byte,
   output logic                          run_last,
   output logic                          text_last
);
   import pde_pkg::*;

   localparam int unsigned IdxWidth = $clog2(JobBytes);

   logic [IdxWidth-1:0]  idx_ff;
   logic                 valid_ff;
   logic [ByteWidth-1:0] byte_ff;
   logic                 run_last_ff;
   logic                 text_last_ff;
   logic                 load;
   logic                 at_end;

   assign load   = !valid_ff || out_ready;
   assign at_end = (CountWidth'(idx_ff) + CountWidth'(1)) == head.count;
   assign pop    = load && !empty && at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= !empty;
         if (!empty) begin
            idx_ff <= at_end ? '0 : idx_ff + IdxWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && !empty) begin
         byte_ff      <= head.bytes[idx_ff];
         run_last_ff  <= at_end;
         text_last_ff <= at_end && head.fin;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign run_last  = run_last_ff;
   assign text_last = text_last_ff;

endmodule

// ===== design/percent_escape_decoder.sv =====
// Streaming percent escape decoder. Each request carries one byte of encoded
// text, with tlast on the final byte of a text. Ordinary bytes pass through;
// a percent sign and two hex digits become one byte, and a percent sign with
// u or U and four hex digits become two bytes, high byte first. Bytes of an
// unfinished escape are held and go out literally when the escape breaks or
// the text ends. A request is taken every cycle while the two-entry batch
// queue has room; a request that yields k bytes holds the result port for
// k transfers (up to six when a broken escape is flushed), and a request that
// only extends an escape yields nothing. The single result register sets the
// output rate at one byte per cycle while rsp_tready stays high, and a byte
// passes through a queue slot and then the result register. Results carry tuser
// on the last byte caused by a request and tlast on the last byte of a text.
module percent_escape_decoder (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pde_pkg::ByteWidth-1:0] req_tdata,   // [7:0] in_byte
   input  logic                          req_tlast,   // final_byte
   // Result channel.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pde_pkg::ByteWidth-1:0] rsp_tdata,   // [7:0] out_byte
   output logic                          rsp_tuser,   // run_last
   output logic                          rsp_tlast    // text_last
);
   import pde_pkg::*;

   logic    accept;
   logic    push;
   logic    pop;
   logic    full;
   logic    empty;
   job_type new_job;
   job_type head_job;

   // The front end never waits on the result port directly; it only needs
   // room in the queue, so ready carries no path from rsp_tready.
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   pde_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_tdata),
      .final_byte (req_tlast),
      .push       (push),
      .job        (new_job)
   );

   pde_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (new_job),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head_job)
   );

   pde_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head_job),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .run_last  (rsp_tuser),
      .text_last (rsp_tlast)
   );

endmodule

// ===== bench/percent_escape_decoder_checker.sv =====
`timescale 1ns / 1ps
// Checker for the percent escape decoder: watches both channels, predicts the
// decoded bytes of every accepted request and compares them in arrival order.
// Depends on pde_pkg for the byte width, the hold depth and the character codes.
module percent_escape_decoder_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [pde_pkg::ByteWidth-1:0] req_tdata,   // [7:0] in_byte
   input  logic                          req_tlast,   // final_byte
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [pde_pkg::ByteWidth-1:0] rsp_tdata,   // [7:0] out_byte
   input  logic                          rsp_tuser,   // run_last
   input  logic                          rsp_tlast,   // text_last
   output int unsigned                   fail_count,
   output int unsigned                   pending
);
   import pde_pkg::*;

   typedef struct packed {
      logic [ByteWidth-1:0] data;
      logic                 run_end;
      logic                 text_end;
   } decoded_byte_type;

   decoded_byte_type     decoded_due [$];
   logic [ByteWidth-1:0] escape_held [HoldDepth];
   int unsigned          escape_len;
   int unsigned          mismatches;

   function automatic logic is_digit_char(input logic [ByteWidth-1:0] b);
      return ((b >= CharZero) && (b <= CharNine)) ||
             ((b >= CharLowerA) && (b <= CharLowerF)) ||
             ((b >= CharUpperA) && (b <= CharUpperF));
   endfunction

   function automatic logic is_u_char(input logic [ByteWidth-1:0] b);
      return (b == CharLowerU) || (b == CharUpperU);
   endfunction

   function automatic logic [3:0] nibble_of(input logic [ByteWidth-1:0] b);
      logic [ByteWidth-1:0] v;
      v = '0;
      if ((b >= CharZero) && (b <= CharNine)) v = b - CharZero;
      else if ((b >= CharLowerA) && (b <= CharLowerF)) v = b - CharLowerA + 8'd10;
      else if ((b >= CharUpperA) && (b <= CharUpperF)) v = b - CharUpperA + 8'd10;
      return v[3:0];
   endfunction

   // Works out every byte one request gives rise to and queues them.
   task automatic decode_request(input logic [ByteWidth-1:0] b, input logic fin);
      logic [ByteWidth-1:0] batch [HoldDepth+1];
      int                   n;
      int                   k;
      logic                 consumed;
      logic                 digit;
      logic                 u_form;
      n        = 0;
      consumed = 1'b0;
      digit    = is_digit_char(b);
      if (escape_len != 0) begin
         u_form = (escape_len >= 2) && is_u_char(escape_held[1]);
         if (escape_len == 1) begin
            if (digit || is_u_char(b)) begin
               escape_held[1] = b;
               escape_len     = 2;
               consumed       = 1'b1;
            end
         end else if ((escape_len == 2) && !u_form) begin
            if (digit) begin
               batch[n]   = {nibble_of(escape_held[1]), nibble_of(b)};
               n++;
               escape_len = 0;
               consumed   = 1'b1;
            end
         end else if (escape_len < HoldDepth) begin
            if (digit) begin
               escape_held[escape_len] = b;
               escape_len++;
               consumed = 1'b1;
            end
         end else begin
            if (digit) begin
               batch[0]   = {nibble_of(escape_held[2]), nibble_of(escape_held[3])};
               batch[1]   = {nibble_of(escape_held[4]), nibble_of(b)};
               n          = 2;
               escape_len = 0;
               consumed   = 1'b1;
            end
         end
         if (!consumed) begin
            for (k = 0; k < escape_len; k++) begin
               batch[n] = escape_held[k];
               n++;
            end
            escape_len = 0;
         end
      end
      if (!consumed) begin
         if (b == CharPercent) begin
            escape_held[0] = b;
            escape_len     = 1;
         end else begin
            batch[n] = b;
            n++;
         end
      end
      if (fin) begin
         for (k = 0; k < escape_len; k++) begin
            batch[n] = escape_held[k];
            n++;
         end
         escape_len = 0;
      end
      for (k = 0; k < n; k++) begin
         decoded_due.push_back(decoded_byte_type'{batch[k], k == n - 1, (k == n - 1) && fin});
      end
   endtask

   always @(posedge clock) begin : watch
      decoded_byte_type want;
      int               k;
      if (reset) begin
         decoded_due.delete();
         escape_len = 0;
         for (k = 0; k < HoldDepth; k++) escape_held[k] = '0;
      end else begin
         if (req_tvalid && req_tready) decode_request(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_due.size() == 0) begin
               $error("unexpected result: out_byte %02h run_last %0d text_last %0d",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               mismatches++;
            end else begin
               want = decoded_due.pop_front();
               if (rsp_tdata !== want.data) begin
                  $error("out_byte: expected %02h, actual %02h", want.data, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser !== want.run_end) begin
                  $error("run_last: expected %0d, actual %0d", want.run_end, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tlast !== want.text_end) begin
                  $error("text_last: expected %0d, actual %0d", want.text_end, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end
      fail_count <= mismatches;
      pending    <= $unsigned(decoded_due.size());
   end

endmodule

// ===== bench/percent_escape_decoder_tb.sv =====
`timescale 1ns / 1ps
// Top of the percent escape decoder bench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on pde_pkg, the decoder and
// percent_escape_decoder_checker, which does all prediction and comparison.
module percent_escape_decoder_tb;
   import pde_pkg::*;

   // The whole run is bounded by this; a correct run needs a small fraction.
   localparam int unsigned RunLimitNs   = 2_000_000;
   localparam int unsigned RandomItems  = 480;
   localparam int unsigned SettleCycles = 16;

   // Kinds of piece that a random text is built from.
   typedef enum logic [2:0] {
      PIECE_PLAIN,
      PIECE_PAIR,
      PIECE_WIDE,
      PIECE_BROKEN,
      PIECE_NOISE
   } text_piece_type;

   // Patterns the result side cycles through when it applies back-pressure.
   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_COIN,
      SINK_SPARSE,
      SINK_HALT
   } sink_mode_type;

   typedef struct packed {
      logic                 fin;
      logic [ByteWidth-1:0] data;
   } text_byte_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ByteWidth-1:0] req_tdata  = '0;   // [7:0] in_byte
   logic                 req_tlast  = 1'b0; // final_byte
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [ByteWidth-1:0] rsp_tdata;         // [7:0] out_byte
   logic                 rsp_tuser;         // run_last
   logic                 rsp_tlast;         // text_last
   int unsigned          fail_count;
   int unsigned          pending;

   text_byte_type        encoded_text [$];
   sink_mode_type        sink_mode  = SINK_OPEN;
   int unsigned          sink_left  = 0;
   int unsigned          sink_phase = 0;

   always #5 clock = ~clock;

   percent_escape_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   percent_escape_decoder_checker monitor (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   function automatic logic [ByteWidth-1:0] random_hex();
      int unsigned pick;
      pick = $urandom_range(0, 21);
      if (pick < 10) return CharZero + ByteWidth'(pick);
      if (pick < 16) return CharLowerA + ByteWidth'(pick - 10);
      return CharUpperA + ByteWidth'(pick - 16);
   endfunction

   task automatic add_byte(input logic [ByteWidth-1:0] b, input logic fin);
      encoded_text.push_back(text_byte_type'{fin, b});
   endtask

   // Queues a literal string; the mark goes on its last character if asked.
   task automatic add_text(input string s, input logic fin);
      int k;
      for (k = 0; k < s.len(); k++) add_byte(s[k], fin && (k == s.len() - 1));
   endtask

   // The result side stalls on its own pattern: fully open stretches, coin
   // flips, one cycle in four, and short complete halts. Each mode lasts a
   // random number of cycles, so stalls land on every phase of a flush.
   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 3));
         sink_left = (sink_mode == SINK_HALT) ? $urandom_range(1, 12) : $urandom_range(8, 64);
      end
      sink_left--;
      sink_phase++;
      case (sink_mode)
         SINK_OPEN:   rsp_tready <= 1'b1;
         SINK_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
         SINK_SPARSE: rsp_tready <= ((sink_phase % 4) == 0);
         default:     rsp_tready <= 1'b0;
      endcase
   end

   initial begin : stimulus
      logic [ByteWidth-1:0] text [$];
      logic [ByteWidth-1:0] piece [6];
      logic [ByteWidth-1:0] b;
      text_piece_type       kind;
      int unsigned          pieces;
      int unsigned          pick;
      int unsigned          full;
      int unsigned          keep;
      int unsigned          goal;
      int unsigned          accepted;
      int unsigned          burst_left;
      int unsigned          gap_left;
      int                   s;
      int                   k;

      // Directed part. Plain extremes, the last of them closing a text; a
      // short escape with a digit pair, one with mixed case, and the long
      // u form. Then a percent sign broken by a letter just past the hex
      // range, a long escape broken at its last digit (six bytes out at
      // once), a double percent that ends the text inside an escape, and a
      // lone boundary character as a one-byte text.
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_text("%09%aF%UfA90", 1'b0);
      add_text("%g", 1'b0);
      add_text("%u123@", 1'b0);
      add_text("%%", 1'b1);
      add_text(":", 1'b1);

      // Random part. Texts mix well-formed escapes that have random digits with
      // plain bytes, broken escapes and raw noise. A broken escape
      // sometimes has no breaking byte, so that a text may end mid-escape.
      goal = encoded_text.size() + RandomItems;
      while (encoded_text.size() < goal) begin
         text.delete();
         pieces = $urandom_range(1, 8);
         for (s = 0; s < pieces; s++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)      kind = PIECE_PLAIN;
            else if (pick < 55) kind = PIECE_PAIR;
            else if (pick < 75) kind = PIECE_WIDE;
            else if (pick < 90) kind = PIECE_BROKEN;
            else                kind = PIECE_NOISE;
            case (kind)
               PIECE_PLAIN: begin
                  b = ByteWidth'($urandom_range(0, 255));
                  if (b == CharPercent) b = ~b;
                  text.push_back(b);
               end
               PIECE_PAIR: begin
                  text.push_back(CharPercent);
                  text.push_back(random_hex());
                  text.push_back(random_hex());
               end
               PIECE_WIDE: begin
                  text.push_back(CharPercent);
                  text.push_back(($urandom_range(0, 1) == 1) ? CharLowerU : CharUpperU);
                  for (k = 0; k < 4; k++) text.push_back(random_hex());
               end
               PIECE_BROKEN: begin
                  full     = ($urandom_range(0, 1) == 1) ? 3 : 6;
                  piece[0] = CharPercent;
                  if (full == 3) piece[1] = random_hex();
                  else piece[1] = ($urandom_range(0, 1) == 1) ? CharLowerU : CharUpperU;
                  for (k = 2; k < 6; k++) piece[k] = random_hex();
                  keep = $urandom_range(1, full - 1);
                  for (k = 0; k < keep; k++) text.push_back(piece[k]);
                  if ($urandom_range(0, 3) != 0) begin
                     // Bytes just outside the hex ranges, another percent, or a random byte.
                     case ($urandom_range(0, 7))
                        0:       b = 8'h2F;
                        1:       b = 8'h3A;
                        2:       b = 8'h40;
                        3:       b = 8'h47;
                        4:       b = 8'h60;
                        5:       b = 8'h67;
                        6:       b = CharPercent;
                        default: b = ByteWidth'($urandom_range(0, 255));
                     endcase
                     text.push_back(b);
                  end
               end
               default: text.push_back(ByteWidth'($urandom_range(0, 255)));
            endcase
         end
         for (k = 0; k < text.size(); k++) add_byte(text[k], k == text.size() - 1);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The sender works in bursts of random length separated by random gaps;
      // roughly one burst in four has no gap after it, giving long unbroken
      // stretches. A request that is not yet accepted is held unchanged.
      accepted   = 0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
      while (accepted < encoded_text.size()) begin
         @(posedge clock);
         if (req_tvalid && req_tready) accepted++;
         if (accepted == encoded_text.size()) begin
            req_tvalid <= 1'b0;
         end else if (req_tvalid && !req_tready) begin
            // Waiting for the block to take the current request.
         end else if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= encoded_text[accepted].data;
            req_tlast  <= encoded_text[accepted].fin;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end

      // The checker's pending count is registered, so let it update first,
      // then wait for the last expected byte and SettleCycles further cycles in case
      // anything unasked for follows.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #(RunLimitNs);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
